/* hw/rtl/irt_pkg.sv */
// Shared constants and types for the interval reservation table.
package irt_pkg;

    // Default table depth and time width.
    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 32;

    // Width of the start and end fields on the ports.
    localparam int FIELD_BITS = 32;

    // Width of the status field on the result port.
    localparam int STATUS_BITS = 2;

    // Result codes for one booking request.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic compare;  // latch the overlap result for the incoming item
        logic shift;    // each cell takes its neighbor's range, the head takes the new range
    } t_cell_ctl;

endpackage

/* hw/rtl/irt_cell.sv */
// One storage cell of the reservation chain: one range, its valid bit and its overlap flag.
module irt_cell #(
    parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  irt_pkg::t_cell_ctl    i_ctl,
    input  logic [TIME_BITS-1:0]  i_req_start,
    input  logic [TIME_BITS-1:0]  i_req_end,
    input  logic [TIME_BITS-1:0]  i_prev_start,
    input  logic [TIME_BITS-1:0]  i_prev_end,
    input  logic                  i_prev_valid,
    output logic [TIME_BITS-1:0]  o_start,
    output logic [TIME_BITS-1:0]  o_end,
    output logic                  o_valid,
    output logic                  o_hit
);
    import irt_pkg::*;

    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_end;
    logic                 r_valid;
    logic                 r_hit;
    logic                 n_hit;

    // A stored range overlaps when it begins before the request ends and ends after it starts.
    always_comb begin
        n_hit = r_valid && (r_start < i_req_end) && (i_req_start < r_end);
    end

    // The range payload shifts along the chain on every insert.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_start <= i_prev_start;
            r_end   <= i_prev_end;
        end
    end

    // Valid bits form a thermometer code that also shifts on insert.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_valid <= i_prev_valid;
            end
            if (i_ctl.compare) begin
                r_hit <= n_hit;
            end
        end
    end

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

/* hw/rtl/interval_reservation_table.sv */
// Top level of the interval reservation table: request control, cell chain and result register.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+------------------------------
//   request  | i_in_valid / o_in_ready | i_start_time, i_end_time
//   result   | o_out_valid / i_out_ready | o_status
//
// On the accepting edge every cell compares its stored range with the request in parallel, and
// in the decide state that follows, the OR of all cell flags selects the status and, for a new
// booking, a range is shifted into the head of the cell chain.
// Reset clears the state machine, the chain's valid bits and hit flags, and the output valid flag.
// A result waiting in the output register does not block the next request; the block holds
// in the decide cycle only while the output register is still occupied.
module interval_reservation_table #(
    parameter int DEPTH     = irt_pkg::DEPTH_DEF,
    parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [irt_pkg::FIELD_BITS-1:0] i_start_time,
    input  logic [irt_pkg::FIELD_BITS-1:0] i_end_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [irt_pkg::STATUS_BITS-1:0] o_status
);
    import irt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_DECIDE = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [TIME_BITS-1:0] r_req_start;
    logic [TIME_BITS-1:0] r_req_end;
    logic                 r_req_empty;
    logic                 r_out_valid;
    t_status              r_status;
    t_status              n_status;

    logic [TIME_BITS-1:0] w_req_start;
    logic [TIME_BITS-1:0] w_req_end;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_commit;
    logic                 w_overlap;
    logic                 w_full;
    logic                 w_insert;
    t_cell_ctl            w_ctl;

    logic [TIME_BITS-1:0] w_cell_start [DEPTH];
    logic [TIME_BITS-1:0] w_cell_end   [DEPTH];
    logic [DEPTH-1:0]     w_cell_valid;
    logic [DEPTH-1:0]     w_cell_hit;

    // Times are taken modulo the time width.
    assign w_req_start = TIME_BITS'(i_start_time);
    assign w_req_end   = TIME_BITS'(i_end_time);

    // Handshakes.
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == S_DECIDE) && w_out_free;

    // Decision from the registered cell flags; the last cell is valid only when the chain is full.
    assign w_overlap = |w_cell_hit;
    assign w_full    = w_cell_valid[DEPTH-1];

    always_comb begin
        n_status = ST_BOOKED;
        w_insert = 1'b0;
        if (r_req_empty) begin
            n_status = ST_BOOKED;
        end else if (w_overlap) begin
            n_status = ST_OVERLAP;
        end else if (w_full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_BOOKED;
            w_insert = 1'b1;
        end
    end

    assign w_ctl.compare = w_accept;
    assign w_ctl.shift   = w_commit && w_insert;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_start <= w_req_start;
            r_req_end   <= w_req_end;
            r_req_empty <= (w_req_end <= w_req_start);
        end
        if (w_commit) begin
            r_status <= n_status;
        end
    end

    // Chain of cells; the head takes the new range, every other cell takes its neighbor's.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [TIME_BITS-1:0] w_prev_start;
        logic [TIME_BITS-1:0] w_prev_end;
        logic                 w_prev_valid;

        if (g == 0) begin : g_head
            assign w_prev_start = r_req_start;
            assign w_prev_end   = r_req_end;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_start = w_cell_start[g-1];
            assign w_prev_end   = w_cell_end[g-1];
            assign w_prev_valid = w_cell_valid[g-1];
        end

        irt_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_req_start  (w_req_start),
            .i_req_end    (w_req_end),
            .i_prev_start (w_prev_start),
            .i_prev_end   (w_prev_end),
            .i_prev_valid (w_prev_valid),
            .o_start      (w_cell_start[g]),
            .o_end        (w_cell_end[g]),
            .o_valid      (w_cell_valid[g]),
            .o_hit        (w_cell_hit[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

/* verif/tb_interval_reservation_table.sv */
// Testbench for the interval reservation table: booking predictor, scoreboard and handshake drivers.
`timescale 1ns / 1ps

// Scoreboard that keeps its own copy of the booking table and the statuses still owed.
class booking_scoreboard;
    logic [irt_pkg::FIELD_BITS-1:0] booked_start[$];
    logic [irt_pkg::FIELD_BITS-1:0] booked_end[$];
    irt_pkg::t_status               owed_status[$];
    int unsigned                    mismatch_count;

    // A stored range collides when it begins before the request ends and ends after it begins.
    function automatic bit collides(logic [irt_pkg::FIELD_BITS-1:0] lo,
                                    logic [irt_pkg::FIELD_BITS-1:0] hi);
        foreach (booked_start[i]) begin
            if (booked_start[i] < hi && lo < booked_end[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the status of one request and record a new booking in the table.
    function automatic irt_pkg::t_status predict_booking(logic [irt_pkg::FIELD_BITS-1:0] lo,
                                                         logic [irt_pkg::FIELD_BITS-1:0] hi);
        if (hi <= lo) return irt_pkg::ST_BOOKED;
        if (collides(lo, hi)) return irt_pkg::ST_OVERLAP;
        if (booked_start.size() >= irt_pkg::DEPTH_DEF) return irt_pkg::ST_FULL;
        booked_start.push_back(lo);
        booked_end.push_back(hi);
        return irt_pkg::ST_BOOKED;
    endfunction

    // Called for each request item the block accepts.
    function automatic void note_request(logic [irt_pkg::FIELD_BITS-1:0] lo,
                                         logic [irt_pkg::FIELD_BITS-1:0] hi);
        owed_status.push_back(predict_booking(lo, hi));
    endfunction

    // Called for each result item the block hands over.
    function automatic void check_status(logic [irt_pkg::STATUS_BITS-1:0] got);
        irt_pkg::t_status want;
        if (owed_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] unexpected result item, status %0d", $realtime, got);
            return;
        end
        want = owed_status.pop_front();
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] status mismatch: expected %0d (%s), got %0d",
                         $realtime, want, want.name(), got);
        end
    endfunction

    function automatic int pending();
        return owed_status.size();
    endfunction
endclass

module tb_interval_reservation_table;
    import irt_pkg::*;

    localparam int RANDOM_ITEMS  = 440;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_ITEM  = 60;
    localparam int DRAIN_AT_ITEM = 220;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int DIRECTED      = 18;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [FIELD_BITS-1:0]  start_time = '0;
    logic [FIELD_BITS-1:0]  end_time   = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [STATUS_BITS-1:0] status;

    booking_scoreboard sb = new;
    bit                hold_out_request = 1'b0;

    // Directed requests: empty forms, touching neighbors, overlaps and the top of the time range.
    logic [FIELD_BITS-1:0] dir_lo [DIRECTED] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100, 32'd200, 32'd0,
        32'd150, 32'd50, 32'd299, 32'd300, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
        32'hF000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd199
    };
    logic [FIELD_BITS-1:0] dir_hi [DIRECTED] = '{
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'd200, 32'd300, 32'd100,
        32'd151, 32'd350, 32'd300, 32'd301, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'h5555_5555,
        32'd201
    };

    interval_reservation_table dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_start_time (start_time),
        .i_end_time   (end_time),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one request item and hold it until the block takes it.
    task automatic send_request(input logic [FIELD_BITS-1:0] lo, input logic [FIELD_BITS-1:0] hi);
        in_valid   <= 1'b1;
        start_time <= lo;
        end_time   <= hi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(lo, hi);
    endtask

    // Drop valid for a number of cycles; zero keeps the stream back to back.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return $urandom_range(15, 40);
        if (roll < 35) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Build a request: mostly free, touching or overlapping ranges next to what is booked.
    function automatic void make_request(output logic [FIELD_BITS-1:0] lo,
                                         output logic [FIELD_BITS-1:0] hi);
        int                    kind;
        int                    idx;
        logic [FIELD_BITS-1:0] len;
        logic [FIELD_BITS-1:0] span;
        logic [FIELD_BITS-1:0] point;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 64);
        idx  = (sb.booked_start.size() > 0) ? $urandom_range(0, sb.booked_start.size() - 1) : 0;
        if (kind < 40 || sb.booked_start.size() == 0) begin
            lo = $urandom;
            hi = lo + len;
        end else if (kind < 55) begin
            if ($urandom_range(0, 1) == 1) begin
                lo = sb.booked_end[idx];
                hi = lo + len;
            end else begin
                hi = sb.booked_start[idx];
                lo = hi - len;
            end
        end else if (kind < 75) begin
            span  = sb.booked_end[idx] - sb.booked_start[idx];
            point = sb.booked_start[idx] + ($urandom % span);
            lo    = point - $urandom_range(0, 8);
            hi    = point + $urandom_range(1, 8);
        end else if (kind < 85) begin
            lo = $urandom;
            hi = ($urandom_range(0, 1) == 1) ? lo : (lo & $urandom);
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
    endfunction

    // Result side: random stalls, with one long hold-off on request from the sender.
    initial begin : result_sink
        int run_len;
        run_len = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_status(status);
            if (hold_out_request) begin
                hold_out_request = 1'b0;
                out_ready <= 1'b0;
                run_len = HOLD_CYCLES;
            end else if (run_len > 0) begin
                run_len--;
            end else if (!out_ready) begin
                out_ready <= 1'b1;
                run_len = $urandom_range(0, 24);
            end else begin
                out_ready <= 1'b0;
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(0, 3);
            end
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("[%0t] no item moved for %0d cycles", $realtime, quiet);
                $display("** interval_reservation_table: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed requests, then the random stream with the two pressure points.
    initial begin : request_source
        logic [FIELD_BITS-1:0] lo;
        logic [FIELD_BITS-1:0] hi;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED; i++) begin
            send_request(dir_lo[i], dir_hi[i]);
            pause_sender(sender_gap());
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM) hold_out_request = 1'b1;
            if (n == DRAIN_AT_ITEM) begin
                pause_sender(1);
                while (sb.pending() != 0) @(posedge clk);
            end
            make_request(lo, hi);
            send_request(lo, hi);
            pause_sender(sender_gap());
        end

        // Let every owed status arrive, then give the block a few more cycles.
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("** interval_reservation_table: PASSED **");
        else
            $display("** interval_reservation_table: FAILED **");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/irt_pkg.sv
hw/rtl/irt_cell.sv
hw/rtl/interval_reservation_table.sv
verif/tb_interval_reservation_table.sv
